// ===== src/ptstat_pkg.sv =====
package ptstat_pkg;

  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [7:0]  SQL_FLAGS        = 8'h18;
  localparam logic [15:0] RESET_MON_PORT   = 16'd1521;
  localparam logic [15:0] RESET_INTERVAL   = 16'd30;
  localparam int          QUEUE_DEPTH      = 4;
  localparam int          QUEUE_AW         = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_MON_PORT = 2'd0,
    CFG_INTERVAL = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    op_t         op;
    logic        is_rx;
    logic        is_sql;
    logic [15:0] len;
  } cmd_t;

  typedef struct packed {
    logic [31:0] tx_packets;
    logic [47:0] tx_bytes;
    logic [15:0] tx_max_size;
    logic [31:0] rx_packets;
    logic [47:0] rx_bytes;
    logic [15:0] rx_max_size;
    logic [31:0] sql_requests;
    logic [47:0] sql_bytes;
  } report_t;

endpackage

// ===== src/ptstat_front.sv =====
module ptstat_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mode,
  input  logic [7:0]         in_ip_protocol,
  input  logic [15:0]        in_src_port,
  input  logic [15:0]        in_dst_port,
  input  logic [7:0]         in_tcp_flags,
  input  logic [15:0]        in_packet_length,
  input  logic [15:0]        mon_port,
  input  logic               q_full,
  output logic               push,
  output ptstat_pkg::cmd_t   cmd
);

  logic last_rx_r;
  logic last_rx_nxt;
  logic src_hit;
  logic dst_hit;
  logic [7:0] flags_eff;

  assign src_hit   = (in_src_port == mon_port);
  assign dst_hit   = (in_dst_port == mon_port);
  assign flags_eff = (in_ip_protocol == ptstat_pkg::PROTO_UDP) ? 8'd0 : in_tcp_flags;
  assign push      = in_valid && !q_full;

  always_comb begin
    cmd.op     = in_mode ? ptstat_pkg::OP_REPORT : ptstat_pkg::OP_PACKET;
    cmd.is_rx  = src_hit ? 1'b0 : (dst_hit ? 1'b1 : last_rx_r);
    cmd.is_sql = (flags_eff == ptstat_pkg::SQL_FLAGS);
    cmd.len    = in_packet_length;
  end

  always_comb begin
    last_rx_nxt = last_rx_r;
    if (push && !in_mode) begin
      if (src_hit) begin
        last_rx_nxt = 1'b0;
      end else if (dst_hit) begin
        last_rx_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rx_r <= 1'b0;
    end else begin
      last_rx_r <= last_rx_nxt;
    end
  end

endmodule

// ===== src/ptstat_fifo.sv =====
module ptstat_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ptstat_pkg::cmd_t   push_data,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output ptstat_pkg::cmd_t   head
);

  localparam int AW = ptstat_pkg::QUEUE_AW;
  localparam int DEPTH = ptstat_pkg::QUEUE_DEPTH;

  ptstat_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full       = (count_r == (AW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/ptstat_div.sv =====
module ptstat_div #(
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [16:0]   rem_sh;
  logic [16:0]   diff;
  logic          ge;

  assign rem_sh   = {rem_r, q_r[DW-1]};
  assign diff     = rem_sh - {1'b0, divisor};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign busy     = busy_r;
  assign quotient = q_r;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], ge};
      rem_nxt = ge ? diff[15:0] : rem_sh[15:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== src/ptstat_back.sv =====
module ptstat_back #(
  parameter int COUNT_WIDTH = 32,
  parameter int BYTE_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  ptstat_pkg::cmd_t      head,
  output logic                  pop,
  input  logic [15:0]           interval,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ptstat_pkg::report_t   rpt,
  output logic [47:0]           sql_rate
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [BYTE_WIDTH-1:0]  BYTE_MAX = {BYTE_WIDTH{1'b1}};

  state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [COUNT_WIDTH-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [COUNT_WIDTH-1:0] sql_cnt_r, sql_cnt_nxt;
  logic [BYTE_WIDTH-1:0]  tx_bytes_r, tx_bytes_nxt;
  logic [BYTE_WIDTH-1:0]  rx_bytes_r, rx_bytes_nxt;
  logic [BYTE_WIDTH-1:0]  sql_bytes_r, sql_bytes_nxt;
  logic [15:0]            tx_max_r, tx_max_nxt;
  logic [15:0]            rx_max_r, rx_max_nxt;

  ptstat_pkg::report_t    rpt_r, rpt_nxt;

  logic                   report_take;
  logic                   div_busy;
  logic [BYTE_WIDTH-1:0]  div_q;
  logic [63:0]            rate_wide;

  function automatic logic [COUNT_WIDTH-1:0] cnt_inc(input logic [COUNT_WIDTH-1:0] a);
    return (a == CNT_MAX) ? a : a + 1'b1;
  endfunction

  function automatic logic [BYTE_WIDTH-1:0] bytes_add(input logic [BYTE_WIDTH-1:0] a,
                                                      input logic [15:0] len);
    logic [BYTE_WIDTH:0] sum;
    sum = {1'b0, a} + (BYTE_WIDTH+1)'(len);
    return sum[BYTE_WIDTH] ? BYTE_MAX : sum[BYTE_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] cnt_out(input logic [COUNT_WIDTH-1:0] a);
    logic [63:0] w;
    w = 64'(a);
    return w[31:0];
  endfunction

  function automatic logic [47:0] bytes_out(input logic [BYTE_WIDTH-1:0] a);
    logic [63:0] w;
    w = 64'(a);
    return w[47:0];
  endfunction

  assign pop = head_valid && (head.op == ptstat_pkg::OP_PACKET || state_r == ST_IDLE);
  assign report_take = pop && (head.op == ptstat_pkg::OP_REPORT);

  ptstat_div #(
    .DW (BYTE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (report_take),
    .dividend (sql_bytes_r),
    .divisor  (interval),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign rate_wide = 64'(div_q);
  assign sql_rate  = rate_wide[47:0];
  assign rpt       = rpt_r;
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (report_take) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tx_cnt_nxt    = tx_cnt_r;
    rx_cnt_nxt    = rx_cnt_r;
    sql_cnt_nxt   = sql_cnt_r;
    tx_bytes_nxt  = tx_bytes_r;
    rx_bytes_nxt  = rx_bytes_r;
    sql_bytes_nxt = sql_bytes_r;
    tx_max_nxt    = tx_max_r;
    rx_max_nxt    = rx_max_r;
    if (report_take) begin
      tx_cnt_nxt    = '0;
      rx_cnt_nxt    = '0;
      sql_cnt_nxt   = '0;
      tx_bytes_nxt  = '0;
      rx_bytes_nxt  = '0;
      sql_bytes_nxt = '0;
      tx_max_nxt    = '0;
      rx_max_nxt    = '0;
    end else if (pop) begin
      if (!head.is_rx) begin
        tx_cnt_nxt   = cnt_inc(tx_cnt_r);
        tx_bytes_nxt = bytes_add(tx_bytes_r, head.len);
        if (head.len > tx_max_r) begin
          tx_max_nxt = head.len;
        end
      end else begin
        rx_cnt_nxt   = cnt_inc(rx_cnt_r);
        rx_bytes_nxt = bytes_add(rx_bytes_r, head.len);
        if (head.len > rx_max_r) begin
          rx_max_nxt = head.len;
        end
        if (head.is_sql) begin
          sql_cnt_nxt   = cnt_inc(sql_cnt_r);
          sql_bytes_nxt = bytes_add(sql_bytes_r, head.len);
        end
      end
    end
  end

  always_comb begin
    rpt_nxt = rpt_r;
    if (report_take) begin
      rpt_nxt.tx_packets   = cnt_out(tx_cnt_r);
      rpt_nxt.tx_bytes     = bytes_out(tx_bytes_r);
      rpt_nxt.tx_max_size  = tx_max_r;
      rpt_nxt.rx_packets   = cnt_out(rx_cnt_r);
      rpt_nxt.rx_bytes     = bytes_out(rx_bytes_r);
      rpt_nxt.rx_max_size  = rx_max_r;
      rpt_nxt.sql_requests = cnt_out(sql_cnt_r);
      rpt_nxt.sql_bytes    = bytes_out(sql_bytes_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tx_cnt_r    <= '0;
      rx_cnt_r    <= '0;
      sql_cnt_r   <= '0;
      tx_bytes_r  <= '0;
      rx_bytes_r  <= '0;
      sql_bytes_r <= '0;
      tx_max_r    <= '0;
      rx_max_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      sql_cnt_r   <= sql_cnt_nxt;
      tx_bytes_r  <= tx_bytes_nxt;
      rx_bytes_r  <= rx_bytes_nxt;
      sql_bytes_r <= sql_bytes_nxt;
      tx_max_r    <= tx_max_nxt;
      rx_max_r    <= rx_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rpt_r <= rpt_nxt;
  end

`ifndef SYNTHESIS
  a_report_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    report_take |-> state_r == ST_IDLE)
    else $error("report taken while a report is in flight");

  a_report_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    report_take |=> state_r == ST_DIV && div_busy)
    else $error("divider not started on report");

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    report_take |=> tx_cnt_r == '0 && rx_cnt_r == '0 && sql_bytes_r == '0)
    else $error("totals not cleared on report");

  a_out_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> !div_busy)
    else $error("result shown while divider busy");
`endif

endmodule

// ===== src/port_traffic_statistics_core.sv =====
// Port traffic statistics core.
// Input channel (in_valid / in_stall): one item per accepted cycle, either
// a packet header (in_mode 0) or an interval end (in_mode 1).
// Packets are classified by direction against the monitored port and summed
// into saturating per-direction counters; they produce no result.
// An interval end produces one result on the out_ channel with all totals and
// the SQL byte rate (SQL bytes / interval seconds), then clears the totals.
// Throughput: one packet per cycle while in_stall is low; the accumulators
// are updated from the head of a 4-entry command queue.
// Interval end: out_valid rises once the one-bit-per-cycle restoring divider
// has finished; packets keep flowing while it runs.
// Out stall: the result holds in its register; later packets still update
// the totals, and a further interval end waits in the queue, which stalls
// the input once full.
// Config (cfg_valid / cfg_ready, always ready): index 0 monitored port,
// index 1 interval seconds; write only while idle.
// Reset: totals and direction cleared, port 1521, interval 30, queue empty.
module port_traffic_statistics_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int BYTE_WIDTH  = 48
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_ip_protocol,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_tcp_flags,
  input  logic [15:0] in_packet_length,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_tx_packets,
  output logic [47:0] out_tx_bytes,
  output logic [15:0] out_tx_max_size,
  output logic [31:0] out_rx_packets,
  output logic [47:0] out_rx_bytes,
  output logic [15:0] out_rx_max_size,
  output logic [31:0] out_sql_requests,
  output logic [47:0] out_sql_bytes,
  output logic [47:0] out_sql_byte_rate,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] mon_port_r, mon_port_nxt;
  logic [15:0] interval_r, interval_nxt;

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_head_valid;
  ptstat_pkg::cmd_t    q_in;
  ptstat_pkg::cmd_t    q_head;
  ptstat_pkg::report_t rpt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    mon_port_nxt = mon_port_r;
    interval_nxt = interval_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptstat_pkg::CFG_MON_PORT: mon_port_nxt = cfg_data;
        ptstat_pkg::CFG_INTERVAL: interval_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_port_r <= ptstat_pkg::RESET_MON_PORT;
      interval_r <= ptstat_pkg::RESET_INTERVAL;
    end else begin
      mon_port_r <= mon_port_nxt;
      interval_r <= interval_nxt;
    end
  end

  ptstat_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_mode          (in_mode),
    .in_ip_protocol   (in_ip_protocol),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .in_tcp_flags     (in_tcp_flags),
    .in_packet_length (in_packet_length),
    .mon_port         (mon_port_r),
    .q_full           (q_full),
    .push             (q_push),
    .cmd              (q_in)
  );

  ptstat_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ptstat_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .BYTE_WIDTH  (BYTE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .interval   (interval_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rpt        (rpt),
    .sql_rate   (out_sql_byte_rate)
  );

  assign out_tx_packets   = rpt.tx_packets;
  assign out_tx_bytes     = rpt.tx_bytes;
  assign out_tx_max_size  = rpt.tx_max_size;
  assign out_rx_packets   = rpt.rx_packets;
  assign out_rx_bytes     = rpt.rx_bytes;
  assign out_rx_max_size  = rpt.rx_max_size;
  assign out_sql_requests = rpt.sql_requests;
  assign out_sql_bytes    = rpt.sql_bytes;

endmodule
